/* rtl/b64sc_pkg.sv */
// Shared types, constants and character functions of the Base64 stream codec.
// Used by every module of the codec; depends on nothing.
package b64sc_pkg;

  localparam int GROUP_W = 24;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR   = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR  = 8'h2F;  // '/'
  localparam logic [5:0] SEXTET_MASK = 6'h3F;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One group handed from the front to the back.
  typedef struct packed {
    logic               dir;     // direction the group was built in
    logic [GROUP_W-1:0] bits;    // packed group bits
    logic [1:0]         fill;    // bytes held by an encode group
    logic [1:0]         cnt_m1;  // number of result beats minus one
    logic               last;    // group closes the stream
    logic               err;     // decode results are errors
  } job_t;

  // Sextet of an alphabet character; bit 6 is set when the character is valid.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h47)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c + 8'h04)};
    else if (c == PLUS_CHAR)           r = {1'b1, 6'd62};
    else if (c == SLASH_CHAR)          r = {1'b1, 6'd63};
    return r;
  endfunction

  // Alphabet character of a sextet.
  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26)      r = 8'h41 + {2'b00, s};
    else if (s < 6'd52) r = 8'h47 + {2'b00, s};
    else if (s < 6'd62) r = {2'b00, s} - 8'h04;
    else if (s == 6'd62) r = PLUS_CHAR;
    else                 r = SLASH_CHAR;
    return r;
  endfunction

endpackage

/* rtl/b64sc_front.sv */
// Front of the Base64 codec: accepts input beats, gathers groups, keeps the
// direction register and pushes finished groups as jobs. Uses b64sc_pkg.
module b64sc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_value,
  input  logic               in_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_direction,
  input  logic               q_full,
  output logic               push,
  output b64sc_pkg::job_t    push_job
);
  import b64sc_pkg::*;

  logic               dir_r, dir_nxt;
  logic [1:0]         fill_r, fill_nxt;
  logic [GROUP_W-1:0] bits_r, bits_nxt;
  logic               twp_r, twp_nxt;
  logic               bad_r, bad_nxt;

  logic               in_acc, cfg_acc;
  logic [6:0]         sx;
  logic               is_pad, bad_new;
  logic [5:0]         s_val;
  logic [GROUP_W-1:0] enc_bits, dec_bits;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !q_full;
  assign cfg_acc   = cfg_valid;

  assign sx      = sextet_of(in_value);
  assign is_pad  = (in_value == PAD_CHAR);
  assign s_val   = (is_pad || !sx[6]) ? 6'd0 : (sx[5:0] & SEXTET_MASK);
  assign bad_new = bad_r | (!is_pad && !sx[6]);
  assign dec_bits = {bits_r[GROUP_W-7:0], s_val};

  always_comb begin
    enc_bits = bits_r;
    case (fill_r)
      2'd0:    enc_bits[23:16] = in_value & BYTE_MASK;
      2'd1:    enc_bits[15:8]  = in_value & BYTE_MASK;
      default: enc_bits[7:0]   = in_value & BYTE_MASK;
    endcase
  end

  always_comb begin
    dir_nxt  = dir_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    twp_nxt  = twp_r;
    bad_nxt  = bad_r;
    push     = 1'b0;
    push_job = '0;
    push_job.dir  = dir_r;
    push_job.last = in_last;
    if (in_acc) begin
      if (dir_r == DIR_ENCODE) begin
        if (fill_r == 2'd2 || in_last) begin
          push            = 1'b1;
          push_job.bits   = enc_bits;
          push_job.fill   = 2'(fill_r + 2'd1);
          push_job.cnt_m1 = 2'd3;
          fill_nxt = '0;
          bits_nxt = '0;
          twp_nxt  = 1'b0;
          bad_nxt  = 1'b0;
        end else begin
          fill_nxt = 2'(fill_r + 2'd1);
          bits_nxt = enc_bits;
        end
      end else begin
        if (fill_r != 2'd3) begin
          if (in_last) begin
            // Stream ended inside a group: one error beat closes it.
            push            = 1'b1;
            push_job.cnt_m1 = 2'd0;
            push_job.err    = 1'b1;
            fill_nxt = '0;
            bits_nxt = '0;
            twp_nxt  = 1'b0;
            bad_nxt  = 1'b0;
          end else begin
            fill_nxt = 2'(fill_r + 2'd1);
            bits_nxt = dec_bits;
            bad_nxt  = bad_new;
            if (fill_r == 2'd2) twp_nxt = is_pad;
          end
        end else begin
          push          = 1'b1;
          push_job.bits = dec_bits;
          push_job.err  = bad_new;
          if (in_last && is_pad && twp_r)      push_job.cnt_m1 = 2'd0;
          else if (in_last && (is_pad || twp_r)) push_job.cnt_m1 = 2'd1;
          else                                 push_job.cnt_m1 = 2'd2;
          fill_nxt = '0;
          bits_nxt = '0;
          twp_nxt  = 1'b0;
          bad_nxt  = in_last ? 1'b0 : bad_new;
        end
      end
    end
    if (cfg_acc) begin
      dir_nxt  = cfg_direction;
      fill_nxt = '0;
      bits_nxt = '0;
      twp_nxt  = 1'b0;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      fill_r <= '0;
      bits_r <= '0;
      twp_r  <= 1'b0;
      bad_r  <= 1'b0;
    end else begin
      dir_r  <= dir_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      twp_r  <= twp_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

/* rtl/b64sc_queue.sv */
// Short job queue between the front and the back of the Base64 codec.
// Uses b64sc_pkg for the job type and depth.
module b64sc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64sc_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output b64sc_pkg::job_t pop_job
);
  import b64sc_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = QCNT_W'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = QCNT_W'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/b64sc_back.sv */
// Back of the Base64 codec: takes jobs from the queue and sends one result
// beat per cycle through an output register, unless stalled. Uses b64sc_pkg.
module b64sc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  b64sc_pkg::job_t q_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_value,
  output logic            out_last,
  output logic            out_error
);
  import b64sc_pkg::*;

  logic       job_valid_r, job_valid_nxt;
  job_t       job_r, job_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_value_r;
  logic       out_last_r, out_error_r;

  logic       emit, job_done;
  logic [5:0] sext;
  logic [7:0] enc_ch, dec_byte, beat_value;

  assign emit     = job_valid_r && (!out_valid_r || !out_stall);
  assign job_done = emit && (k_r == job_r.cnt_m1);
  assign pop      = !q_empty && (!job_valid_r || job_done);

  always_comb begin
    case (k_r)
      2'd0:    sext = job_r.bits[23:18];
      2'd1:    sext = job_r.bits[17:12];
      2'd2:    sext = job_r.bits[11:6];
      default: sext = job_r.bits[5:0];
    endcase
    enc_ch = char_of(sext);
    if ((job_r.fill == 2'd1 && k_r >= 2'd2) || (job_r.fill == 2'd2 && k_r == 2'd3)) begin
      enc_ch = PAD_CHAR;
    end
    case (k_r)
      2'd0:    dec_byte = job_r.bits[23:16];
      2'd1:    dec_byte = job_r.bits[15:8];
      2'd2:    dec_byte = job_r.bits[7:0];
      default: dec_byte = 8'd0;
    endcase
    if (job_r.dir == DIR_ENCODE) beat_value = enc_ch;
    else if (job_r.err)          beat_value = 8'd0;
    else                         beat_value = dec_byte;
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      k_nxt         = 2'(k_r + 2'd1);
    end
    if (job_done) job_valid_nxt = 1'b0;
    if (pop) begin
      job_valid_nxt = 1'b1;
      job_nxt       = q_job;
      k_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_value_r <= beat_value;
      out_last_r  <= job_r.last && (k_r == job_r.cnt_m1);
      out_error_r <= (job_r.dir == DIR_DECODE) && job_r.err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

endmodule

/* rtl/base64_stream_codec_top.sv */
// Top level of the Base64 stream codec: front, job queue and back.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//
// Usage notes.
// The input channel (in_valid, in_stall, in_value, in_last) takes one byte or
// one character per beat; in_last marks the final beat of a stream. The output
// channel (out_valid, out_stall, out_value, out_last, out_error) returns one
// character or byte per beat. A beat moves on a rising edge where valid is high
// and stall is low. The configuration channel (cfg_valid, cfg_ready,
// cfg_direction) writes the direction: 0 encodes, 1 decodes. A write also
// clears any partly gathered group, and should only be issued while idle.
// A beat that completes a group is written into the job queue, loaded into
// the back's job register and then into the output register, where its first
// result shows. The back sends one result per cycle while the receiver does
// not stall, so encoding, with four characters for every three bytes, is held
// by the output side; decoding sustains one character per cycle. The front
// keeps accepting beats while the two-entry job queue has room, so a stalled
// result does not stop input until the queue fills. When the receiver stalls,
// the output beat holds steady. Reset (synchronous, active low) empties the
// queue and output, clears the group state and selects encode.
module base64_stream_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic       out_last,
  output logic       out_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction
);
  import b64sc_pkg::*;

  logic q_full, q_empty, push, pop;
  job_t push_job, pop_job;

  // The front gathers groups and hands each completed one to the queue.
  b64sc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_direction (cfg_direction),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  // The queue lets the front run ahead while the receiver stalls.
  b64sc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  // The back expands each job into its result beats.
  b64sc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

/* rtl/b64sc_checker.sv */
// Port-level checks for the Base64 codec top level, with the bind that
// attaches them. Depends only on the top level's ports.
module b64sc_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_value,
  input logic       out_last,
  input logic       out_error
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last)
      && $stable(out_error))
    else $error("result beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // An error beat always carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_value == 8'd0)
    else $error("error beat with nonzero value");

endmodule

bind base64_stream_codec_top b64sc_port_checks u_b64sc_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value),
  .out_last  (out_last),
  .out_error (out_error)
);

/* sim/b64sc_checker.sv */
`timescale 1ns / 100ps
// Result checker for the Base64 stream codec: watches the three channels, predicts
// every result beat and compares it field by field. Depends on b64sc_pkg.
module b64sc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_value,
  input  logic       out_last,
  input  logic       out_error,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_direction,
  output int         fail_count,
  output int         expect_depth
);
  import b64sc_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       error;
  } codec_beat_t;

  codec_beat_t        want_q[$];
  logic               dir_q;
  int                 fill;
  logic [23:0]        gbits;
  logic               third_pad;
  logic               bad_seen;

  function automatic logic [7:0] char_for(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + s;
    if (s < 6'd52) return 8'h61 + (s - 6'd26);
    if (s < 6'd62) return 8'h30 + (s - 6'd52);
    if (s == 6'd62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  function automatic int sextet_for(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 65;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 97 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48 + 52;
    if (c == PLUS_CHAR) return 62;
    if (c == SLASH_CHAR) return 63;
    return -1;
  endfunction

  task automatic clear_group();
    fill = 0;
    gbits = '0;
    third_pad = 1'b0;
    bad_seen = 1'b0;
  endtask

  task automatic push_want(input logic [7:0] v, input logic l, input logic e);
    codec_beat_t b;
    b.value = v;
    b.last = l;
    b.error = e;
    want_q.push_back(b);
  endtask

  task automatic report_mismatch(input string what);
    // Printing stops after a while on a badly broken build; counting does not.
    if (fail_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_encode(input logic [7:0] b, input logic l);
    logic [7:0] ch;
    int         k;
    gbits = gbits | ({16'd0, b} << (16 - 8 * fill));
    fill++;
    if (fill < 3 && !l) return;
    for (k = 0; k < 4; k++) begin
      ch = char_for(gbits[23 - 6 * k -: 6]);
      if ((fill == 1 && k >= 2) || (fill == 2 && k == 3)) ch = PAD_CHAR;
      push_want(ch, l && k == 3, 1'b0);
    end
    clear_group();
  endtask

  task automatic predict_decode(input logic [7:0] c, input logic l);
    logic [5:0] s;
    logic       err;
    int         v;
    int         n;
    int         k;
    s = '0;
    if (c != PAD_CHAR) begin
      v = sextet_for(c);
      if (v < 0) bad_seen = 1'b1;
      else s = v[5:0];
    end
    if (fill == 2) third_pad = (c == PAD_CHAR);
    gbits = {gbits[17:0], s};
    if (fill < 3) begin
      fill++;
      if (!l) return;
      // A stream that stops inside a group yields a single error beat.
      push_want(8'h00, 1'b1, 1'b1);
      clear_group();
      return;
    end
    n = 3;
    if (l) begin
      if (c == PAD_CHAR) n--;
      if (third_pad) n--;
    end
    err = bad_seen;
    for (k = 0; k < n; k++)
      push_want(err ? 8'h00 : gbits[23 - 8 * k -: 8], l && k == n - 1, err);
    fill = 0;
    gbits = '0;
    third_pad = 1'b0;
    if (l) bad_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    codec_beat_t got;
    if (!rst_n) begin
      dir_q = DIR_ENCODE;
      clear_group();
      want_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_q = cfg_direction;
        clear_group();
      end
      if (in_valid && !in_stall) begin
        if (dir_q == DIR_ENCODE) predict_encode(in_value, in_last);
        else predict_decode(in_value, in_last);
      end
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", out_value));
        end else begin
          got = want_q.pop_front();
          if (out_value !== got.value)
            report_mismatch($sformatf("out_value %h, expected %h", out_value, got.value));
          if (out_last !== got.last)
            report_mismatch($sformatf("out_last %b, expected %b", out_last, got.last));
          if (out_error !== got.error)
            report_mismatch($sformatf("out_error %b, expected %b", out_error, got.error));
        end
      end
    end
    expect_depth = want_q.size();
  end

endmodule

/* sim/base64_stream_codec_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top of the Base64 stream codec: clock, reset, stimulus and verdict.
// Depends on b64sc_pkg, base64_stream_codec_top and b64sc_checker.
module base64_stream_codec_top_tb;
  import b64sc_pkg::*;

  // Roughly how many input beats the whole run offers.
  localparam int ITEM_TARGET  = 460;
  // Length of the long receiver hold-off that fills the job queue.
  localparam int HOLD_CYCLES  = 300;
  // Cycles allowed after the last expected beat for the pipeline to settle;
  // an accepted beat passes the queue, job and output registers before its result.
  localparam int DRAIN_CYCLES = 10;
  // Far beyond the slowest correct run.
  localparam int TIMEOUT_NS   = 1_000_000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_value;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_value;
  logic       out_last;
  logic       out_error;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_direction;

  int         fail_count;
  int         expect_depth;

  // Upper bounds of the random gaps on each side; a bound of zero gives a
  // stretch with no idling at all on that side.
  int         tx_idle_max;
  int         rx_idle_max;
  // Set by the stimulus to make the receiver hold off for HOLD_CYCLES.
  logic       hold_req;
  int         sent_items;

  always #1 clk = ~clk;

  base64_stream_codec_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_error     (out_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_direction (cfg_direction)
  );

  b64sc_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_error     (out_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_direction (cfg_direction),
    .fail_count    (fail_count),
    .expect_depth  (expect_depth)
  );

  // Alphabet symbol of a sextet, used to build well-formed decode streams.
  function automatic logic [7:0] b64_symbol(input int s);
    if (s < 26) return 8'(65 + s);
    if (s < 52) return 8'(97 + s - 26);
    if (s < 62) return 8'(48 + s - 52);
    if (s == 62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  // Offers one input beat after a random gap and returns at the edge that takes it.
  // Handshake signals are sampled at the falling edge, where everything has
  // settled, so the decision never depends on event order at the rising edge.
  // in_valid is lowered only when a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] v, input logic l);
    int   gap;
    logic hit;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk);
      hit = !in_stall;
      @(posedge clk);
    end
    sent_items++;
  endtask

  task automatic send_text(input string txt, input bit close);
    int i;
    for (i = 0; i < txt.len(); i++) send_beat(txt[i], close && i == txt.len() - 1);
  endtask

  // Writes the direction once the block has gone quiet: every expected beat
  // has come back and a few more cycles have passed for groups still held.
  task automatic set_direction(input logic d);
    logic hit;
    in_valid <= 1'b0;
    @(negedge clk);
    while (expect_depth != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk);
      hit = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // A run of random bytes; close decides whether the last one ends the stream.
  task automatic send_encode_stream(input int len, input bit close);
    int i;
    for (i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), close && i == len - 1);
  endtask

  // About half well-formed text with random content and padding, the rest is
  // broken on purpose: a stray byte, a pad out of place, a wrong length, or noise.
  task automatic send_decode_stream(input bit close);
    logic [7:0] chars[$];
    int         ng;
    int         pads;
    int         i;
    ng = $urandom_range(1, 3);
    for (i = 0; i < ng * 4; i++) chars.push_back(b64_symbol($urandom_range(0, 63)));
    pads = $urandom_range(0, 2);
    if ($urandom_range(0, 19) == 0) pads = 4;
    for (i = 0; i < pads; i++) chars[chars.size() - 1 - i] = PAD_CHAR;
    case ($urandom_range(0, 9))
      0: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      1: chars[$urandom_range(0, chars.size() - 1)] = PAD_CHAR;
      2: repeat ($urandom_range(1, 3)) void'(chars.pop_back());
      3: repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
      4: begin
        chars.delete();
        repeat ($urandom_range(1, 9)) chars.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    for (i = 0; i < chars.size(); i++) send_beat(chars[i], close && i == chars.size() - 1);
  endtask

  // Receiver: before each result beat it waits a random number of cycles with
  // out_stall high, or the long hold-off when one has been asked for. The hold
  // is counted here, independent of the sender, which keeps offering beats.
  initial begin : rx_side
    int   n;
    logic hit;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, rx_idle_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      hit = 1'b0;
      while (!hit) begin
        @(negedge clk);
        hit = out_valid;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   phase;
    int   phase_end;
    logic dir;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = 8'h00;
    in_last       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_direction = DIR_ENCODE;
    hold_req      = 1'b0;
    tx_idle_max   = 10;
    rx_idle_max   = 10;
    sent_items    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed encode: a lone 0xFF (two pads), 0x00 0xFF (one pad), a full
    // group, and a byte left hanging that the next direction write discards.
    set_direction(DIR_ENCODE);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_text("Man", 1'b1);
    send_beat(8'h5A, 1'b0);

    // Directed decode: two pads, a final group of pads only, a pad in the middle
    // followed by a bad character whose error runs on into the next group, and
    // a stream that stops two characters into a group.
    set_direction(DIR_DECODE);
    send_text("TQ==", 1'b1);
    send_text("====", 1'b1);
    send_text("T=F*AB==", 1'b1);
    send_text("QQ", 1'b1);

    // Random phases alternate the direction. Each picks its own idling style,
    // and one of them runs the sender flat out against a long receiver hold.
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      dir = (phase % 2 == 1) ? DIR_DECODE : DIR_ENCODE;
      set_direction(dir);
      case ($urandom_range(0, 3))
        0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
        1: begin tx_idle_max = 10; rx_idle_max = 0;  end
        2: begin tx_idle_max = 0;  rx_idle_max = 10; end
        default: begin tx_idle_max = 10; rx_idle_max = 10; end
      endcase
      if (phase == 2) begin
        tx_idle_max = 0;
        hold_req = 1'b1;
      end
      phase_end = sent_items + $urandom_range(30, 60);
      while (sent_items < phase_end) begin
        if (dir == DIR_ENCODE) send_encode_stream($urandom_range(1, 10), $urandom_range(0, 9) != 0);
        else send_decode_stream($urandom_range(0, 9) != 0);
      end
      phase++;
    end

    // Drain: wait for every expected beat, then a few cycles for stray results.
    in_valid <= 1'b0;
    @(negedge clk);
    while (expect_depth != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/b64sc_pkg.sv
rtl/b64sc_front.sv
rtl/b64sc_queue.sv
rtl/b64sc_back.sv
rtl/base64_stream_codec_top.sv
rtl/b64sc_checker.sv
sim/b64sc_checker.sv
sim/base64_stream_codec_top_tb.sv
